/* sv/rbr_pkg.sv */
// Shared types and constants for the receive byte ring.
`default_nettype none

package rbr_pkg;

  // Field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned CntW  = 32;
  localparam int unsigned OpW   = 2;

  // Input word operation codes
  typedef enum logic [OpW-1:0] {
    OP_RECEIVE = 2'd0,
    OP_READ    = 2'd1,
    OP_OVERRUN = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  // Ring memory access strobes for one word
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage : rbr_pkg

`default_nettype wire

/* sv/rbr_ram.sv */
// Ring storage: single write port, single read port, registered read data.
`default_nettype none

module rbr_ram
  import rbr_pkg::*;
#(
  parameter int unsigned Depth = 128,
  parameter int unsigned AddrW = 7
) (
  input  wire  logic             clk_i,
  input  wire  mem_ctl_t         mem_ctl_i,
  input  wire  logic [AddrW-1:0] wr_addr_i,
  input  wire  logic [ByteW-1:0] wr_data_i,
  input  wire  logic [AddrW-1:0] rd_addr_i,
  output logic       [ByteW-1:0] rd_data_o
);

  logic [ByteW-1:0] mem_q [Depth];
  logic [ByteW-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule : rbr_ram

`default_nettype wire

/* sv/rbr_ctrl.sv */
// Ring pointers, full/empty decisions and the drop and overrun counters.
`default_nettype none

module rbr_ctrl
  import rbr_pkg::*;
#(
  parameter int unsigned Depth = 128,
  parameter int unsigned IdxW  = 7
) (
  input  wire  logic             clk_i,
  input  wire  logic             rst_ni,
  input  wire  logic             accept_i,
  input  wire  op_e              op_i,
  input  wire  logic [ByteW-1:0] rx_byte_i,
  output mem_ctl_t               mem_ctl_o,
  output logic       [IdxW-1:0]  wr_addr_o,
  output logic       [ByteW-1:0] wr_data_o,
  output logic       [IdxW-1:0]  rd_addr_o,
  output logic       [CntW-1:0]  overflow_count_o,
  output logic       [CntW-1:0]  overrun_count_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  logic [IdxW-1:0] wr_idx_q, wr_idx_d, wr_idx_nxt;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d, rd_idx_nxt;
  logic [CntW-1:0] overflow_q, overflow_d;
  logic [CntW-1:0] overrun_q, overrun_d;
  logic            full, empty;

  // Wrapping pointer advance, also for depths that are not a power of two
  assign wr_idx_nxt = (wr_idx_q == LastIdx) ? '0 : wr_idx_q + IdxW'(1);
  assign rd_idx_nxt = (rd_idx_q == LastIdx) ? '0 : rd_idx_q + IdxW'(1);

  // Ring keeps one slot free
  assign full  = (wr_idx_nxt == rd_idx_q);
  assign empty = (wr_idx_q == rd_idx_q);

  // Decode one accepted word
  always_comb begin
    mem_ctl_o  = '0;
    wr_idx_d   = wr_idx_q;
    rd_idx_d   = rd_idx_q;
    overflow_d = overflow_q;
    overrun_d  = overrun_q;
    if (accept_i) begin
      unique case (op_i)
        OP_RECEIVE: begin
          if (full) begin
            overflow_d = overflow_q + CntW'(1);
          end else begin
            mem_ctl_o.wr_en = 1'b1;
            wr_idx_d        = wr_idx_nxt;
          end
        end
        OP_READ: begin
          if (!empty) begin
            mem_ctl_o.rd_en = 1'b1;
            rd_idx_d        = rd_idx_nxt;
          end
        end
        OP_OVERRUN: begin
          overrun_d = overrun_q + CntW'(1);
        end
        OP_CLEAR: begin
          overflow_d = '0;
          overrun_d  = '0;
        end
        default: begin
          overflow_d = overflow_q;
        end
      endcase
    end
  end

  // Pointer and counter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q   <= '0;
      rd_idx_q   <= '0;
      overflow_q <= '0;
      overrun_q  <= '0;
    end else begin
      wr_idx_q   <= wr_idx_d;
      rd_idx_q   <= rd_idx_d;
      overflow_q <= overflow_d;
      overrun_q  <= overrun_d;
    end
  end

  assign wr_addr_o        = wr_idx_q;
  assign wr_data_o        = rx_byte_i;
  assign rd_addr_o        = rd_idx_q;
  assign overflow_count_o = overflow_q;
  assign overrun_count_o  = overrun_q;

`ifndef SYNTHESIS
  // A word either pushes or pops, never both
  a_no_dual_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctl_o.wr_en && mem_ctl_o.rd_en))
    else $error("ring written and read by the same word");

  // A pop only happens on a non-empty ring
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl_o.rd_en |-> (rd_idx_q != wr_idx_q))
    else $error("pop from empty ring");

  // Clear leaves both counters at zero
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && (op_i == OP_CLEAR)) |=> ((overflow_q == '0) && (overrun_q == '0)))
    else $error("counters not cleared");
`endif

endmodule : rbr_ctrl

`default_nettype wire

/* sv/rx_byte_ring_with_drop_counters.sv */
// An accepted word passes the read stage register and then the output word register.
// A new word is not taken until the previous one has left the read stage, which waits on the ring memory read.
// The input waits while a result sits in the read stage or the output word is stalled.
// Reset (rst_ni, async, active low) clears pointers, counters and valid flags.
// Ring memory contents are not reset; only written entries are ever popped.
`default_nettype none

module rx_byte_ring_with_drop_counters
  import rbr_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 128
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  wire  logic [1:0]  s_axis_tuser,  // [1:0] operation
  output logic              m_axis_tvalid,
  input  wire  logic        m_axis_tready,
  output logic [71:0]       m_axis_tdata,  // [7:0] byte_out, [39:8] overflow_count,
                                           // [71:40] overrun_count
  output logic [0:0]        m_axis_tuser   // [0] byte_valid
);

  localparam int unsigned IdxW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  logic             accept;
  logic             out_free;
  mem_ctl_t         mem_ctl;
  logic [IdxW-1:0]  wr_addr;
  logic [IdxW-1:0]  rd_addr;
  logic [ByteW-1:0] wr_data;
  logic [ByteW-1:0] rd_data;
  logic [CntW-1:0]  overflow_count;
  logic [CntW-1:0]  overrun_count;

  logic             s1_valid_q;
  logic             s1_pop_q;
  logic             out_valid_q;
  logic             out_byte_valid_q;
  logic [71:0]      out_data_q;

  // Input side handshake
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  rbr_ctrl #(
    .Depth (RING_DEPTH),
    .IdxW  (IdxW)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .op_i             (op_e'(s_axis_tuser)),
    .rx_byte_i        (s_axis_tdata),
    .mem_ctl_o        (mem_ctl),
    .wr_addr_o        (wr_addr),
    .wr_data_o        (wr_data),
    .rd_addr_o        (rd_addr),
    .overflow_count_o (overflow_count),
    .overrun_count_o  (overrun_count)
  );

  rbr_ram #(
    .Depth (RING_DEPTH),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i     (clk_i),
    .mem_ctl_i (mem_ctl),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Read stage: waits for the memory read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_pop_q   <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s1_pop_q   <= mem_ctl.rd_en;
    end
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_valid_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      out_byte_valid_q <= s1_pop_q;
      out_data_q       <= {overrun_count, overflow_count,
                           (s1_pop_q ? rd_data : {ByteW{1'b0}})};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_byte_valid_q;

`ifndef SYNTHESIS
  // Pending read stage blocks new words
  a_s1_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> !s_axis_tready)
    else $error("word accepted while read stage busy");

  // Read stage always lands in the output register
  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> m_axis_tvalid)
    else $error("result lost between read stage and output");

  // Accepted word always reaches the read stage
  a_accept_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted word not tracked");
`endif

endmodule : rx_byte_ring_with_drop_counters

`default_nettype wire
